// ===== hdl/radix_calculator_digit_emitter_core_assert.svh =====
// Assertion macros shared by the digit emitter RTL.
// Needs clk (and arst_n for RCDE_ASSERT) in the scope of each use; no other dependencies.
`ifndef RADIX_CALCULATOR_DIGIT_EMITTER_CORE_ASSERT_SVH
`define RADIX_CALCULATOR_DIGIT_EMITTER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// checked only outside reset
`define RCDE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// checked at every edge, reset included
`define RCDE_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RCDE_ASSERT(lbl, prop, msg)
`define RCDE_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== hdl/rcde_pkg.sv =====
// Package for the radix digit emitter: field widths, codes, queue control type
// and the digit glyph function. No dependencies.
package rcde_pkg;

	localparam int OPERAND_W          = 64;
	localparam int MODE_W             = 3;
	localparam int BASE_W             = 6;
	localparam int CHAR_W             = 7;
	localparam int STATUS_W           = 2;
	localparam int DIGIT_W            = 6;
	localparam int VALUE_BITS_DEF     = 64;
	localparam int MAX_DIGITS_DEF     = 64;
	localparam int QUEUE_DEPTH        = 2;
	localparam int DIV_BITS_PER_CYCLE = 8;

	localparam logic [BASE_W-1:0]  BASE_MIN     = 6'd2;
	localparam logic [BASE_W-1:0]  BASE_MAX     = 6'd36;
	localparam logic [DIGIT_W-1:0] RADIX_DIGITS = 6'd10;
	localparam logic [DIGIT_W-1:0] GLYPH_COUNT  = 6'd36;
	localparam logic [CHAR_W-1:0]  CHAR_ZERO    = 7'h30;
	localparam logic [CHAR_W-1:0]  CHAR_A       = 7'h41;

	typedef enum logic [MODE_W-1:0] {
		MODE_CONVERT = 3'd0,
		MODE_ADD     = 3'd1,
		MODE_SUB     = 3'd2,
		MODE_MUL     = 3'd3,
		MODE_DIV     = 3'd4
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK       = 2'd0,
		STATUS_DIV_ZERO = 2'd1,
		STATUS_BAD_BASE = 2'd2
	} status_t;

	// control part of a queue entry between front and back
	typedef struct packed {
		status_t             status;
		logic [BASE_W-1:0]   base;
	} qctl_t;

	localparam int CTL_W = $bits(qctl_t);

	// digit value to ASCII '0'-'9', 'A'-'Z'
	function automatic logic [CHAR_W-1:0] digit_glyph(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] g;
		if (d < RADIX_DIGITS) begin
			g = CHAR_ZERO + CHAR_W'(d);
		end else if (d < GLYPH_COUNT) begin
			g = CHAR_A + CHAR_W'(d - RADIX_DIGITS);
		end else begin
			g = CHAR_ZERO;
		end
		return g;
	endfunction

endpackage

// ===== hdl/rcde_in_if.sv =====
// Request channel: mode, two operands and target base with valid/ready.
// Depends on rcde_pkg.
interface rcde_in_if;
	import rcde_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [MODE_W-1:0]    mode;
	logic [OPERAND_W-1:0] operand_a;
	logic [OPERAND_W-1:0] operand_b;
	logic [BASE_W-1:0]    base;

	modport source (output valid, mode, operand_a, operand_b, base, input ready);
	modport sink   (input valid, mode, operand_a, operand_b, base, output ready);
endinterface

// ===== hdl/rcde_out_if.sv =====
// Digit channel: one ASCII digit, last marker and status per item.
// Depends on rcde_pkg.
interface rcde_out_if;
	import rcde_pkg::*;

	logic                valid;
	logic                ready;
	logic [CHAR_W-1:0]   digit_char;
	logic                last;
	logic [STATUS_W-1:0] status;

	modport source (output valid, digit_char, last, status, input ready);
	modport sink   (input valid, digit_char, last, status, output ready);
endinterface

// ===== hdl/rcde_ram.sv =====
// Generic single write port RAM with registered read.
// No dependencies.
module rcde_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== hdl/rcde_front.sv =====
// Front end: accepts requests, flags bad base and division by zero, and forms
// the value (add, saturating subtract, split multiply, serial divide).
// Depends on rcde_pkg, rcde_in_if and the assertion header.
`include "radix_calculator_digit_emitter_core_assert.svh"
module rcde_front #(
	parameter int VALUE_BITS = rcde_pkg::VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	rcde_in_if.sink               cmd,
	output logic                  push_valid,
	input  logic                  push_ready,
	output rcde_pkg::qctl_t       push_ctl,
	output logic [VALUE_BITS-1:0] push_value
);
	import rcde_pkg::*;

	localparam int VB      = VALUE_BITS;
	localparam int HALF_W  = (VB + 1) / 2;
	localparam int DSTEP_W = $clog2(VB);

	typedef enum logic [1:0] {F_IDLE, F_MUL, F_DIV, F_PUSH} fstate_t;

	fstate_t              state_q;
	logic [VB-1:0]        a_q, b_q, val_q, rem_q;
	qctl_t                ctl_q;
	logic [1:0]           mstep_q;
	logic [DSTEP_W-1:0]   dstep_q;
	logic [2*HALF_W-1:0]  prod_q;

	logic [VB-1:0]        a_in, b_in;
	logic                 base_bad;
	status_t              status_in;
	mode_t                mode_in;
	logic [HALF_W-1:0]    mul_x, mul_y;
	logic [VB-1:0]        prod_add;
	logic [VB:0]          rem_sh, b_ext;
	logic                 rem_ge;

	// input decode
	assign a_in     = cmd.operand_a[VB-1:0];
	assign b_in     = cmd.operand_b[VB-1:0];
	assign mode_in  = mode_t'(cmd.mode);
	assign base_bad = (cmd.base < BASE_MIN) || (cmd.base > BASE_MAX);

	// bad base wins over division by zero
	assign status_in = base_bad ? STATUS_BAD_BASE :
	                   ((mode_in == MODE_DIV) && (b_in == '0)) ? STATUS_DIV_ZERO : STATUS_OK;

	// partial product select: lo*lo, lo*hi, hi*lo; hi*hi falls off the top
	always_comb begin
		case (mstep_q)
			2'd0: begin
				mul_x = a_q[HALF_W-1:0];
				mul_y = b_q[HALF_W-1:0];
			end
			2'd1: begin
				mul_x = a_q[HALF_W-1:0];
				mul_y = HALF_W'(b_q[VB-1:HALF_W]);
			end
			default: begin
				mul_x = HALF_W'(a_q[VB-1:HALF_W]);
				mul_y = b_q[HALF_W-1:0];
			end
		endcase
	end

	// product from the previous step, aligned; first one has no shift
	assign prod_add = (mstep_q == 2'd1) ? VB'(prod_q) : (VB'(prod_q) << HALF_W);

	// restoring divide, one quotient bit per cycle
	assign rem_sh = {rem_q, val_q[VB-1]};
	assign b_ext  = {1'b0, b_q};
	assign rem_ge = (rem_sh >= b_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			mstep_q <= '0;
			dstep_q <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (cmd.valid) begin
						a_q          <= a_in;
						b_q          <= b_in;
						ctl_q.base   <= cmd.base;
						ctl_q.status <= status_in;
						mstep_q      <= '0;
						dstep_q      <= '0;
						rem_q        <= '0;
						if (base_bad) begin
							val_q   <= '0;
							state_q <= F_PUSH;
						end else begin
							case (mode_in)
								MODE_ADD: begin
									val_q   <= a_in + b_in;
									state_q <= F_PUSH;
								end
								MODE_SUB: begin
									val_q   <= (a_in > b_in) ? (a_in - b_in) : '0;
									state_q <= F_PUSH;
								end
								MODE_MUL: begin
									val_q   <= '0;
									state_q <= F_MUL;
								end
								MODE_DIV: begin
									if (b_in == '0) begin
										val_q   <= '0;
										state_q <= F_PUSH;
									end else begin
										val_q   <= a_in;
										state_q <= F_DIV;
									end
								end
								default: begin
									val_q   <= a_in;
									state_q <= F_PUSH;
								end
							endcase
						end
					end
				end
				F_MUL: begin
					prod_q  <= mul_x * mul_y;
					mstep_q <= mstep_q + 2'd1;
					if (mstep_q != 2'd0) begin
						val_q <= val_q + prod_add;
					end
					if (mstep_q == 2'd3) begin
						state_q <= F_PUSH;
					end
				end
				F_DIV: begin
					rem_q   <= rem_ge ? VB'(rem_sh - b_ext) : rem_sh[VB-1:0];
					val_q   <= {val_q[VB-2:0], rem_ge};
					dstep_q <= dstep_q + 1'b1;
					if (dstep_q == DSTEP_W'(VB - 1)) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (push_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	assign cmd.ready  = (state_q == F_IDLE);
	assign push_valid = (state_q == F_PUSH);
	assign push_ctl   = ctl_q;
	assign push_value = val_q;

	// one request at a time: nothing accepted right after an accept
	`RCDE_ASSERT(a_front_single, cmd.valid && cmd.ready |=> !cmd.ready, "back-to-back accept")
endmodule

// ===== hdl/rcde_queue.sv =====
// Short register FIFO between front and back ends.
// Depends on the assertion header.
`include "radix_calculator_digit_emitter_core_assert.svh"
module rcde_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  logic [WIDTH-1:0] wr_data,
	output logic             rd_valid,
	input  logic             rd_ready,
	output logic [WIDTH-1:0] rd_data
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wptr_q, rptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr, do_rd;

	assign wr_ready = (cnt_q != CNT_W'(DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;
	assign rd_data  = mem_q[rptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`RCDE_ASSERT_ALWAYS(a_queue_cnt_bound, cnt_q <= CNT_W'(DEPTH), "queue fill count beyond depth")
endmodule

// ===== hdl/rcde_back.sv =====
// Back end: passes flagged items straight to the output; splits other values into
// base-b digits by serial division, stores them in the digit RAM, then emits them most significant first.
// Depends on rcde_pkg, rcde_out_if, rcde_ram and the assertion header.
`include "radix_calculator_digit_emitter_core_assert.svh"
module rcde_back #(
	parameter int VALUE_BITS = rcde_pkg::VALUE_BITS_DEF,
	parameter int MAX_DIGITS = rcde_pkg::MAX_DIGITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	output logic                  q_ready,
	input  rcde_pkg::qctl_t       q_ctl,
	input  logic [VALUE_BITS-1:0] q_value,
	rcde_out_if.source            dig
);
	import rcde_pkg::*;

	localparam int DBITS  = DIV_BITS_PER_CYCLE;
	localparam int CHUNKS = (VALUE_BITS + DBITS - 1) / DBITS;
	localparam int PADW   = CHUNKS * DBITS;
	localparam int CHK_W  = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
	localparam int AW     = $clog2(MAX_DIGITS);
	localparam int CW     = $clog2(MAX_DIGITS + 1);

	typedef enum logic [2:0] {B_IDLE, B_CHECK, B_DIV, B_RD, B_LD} bstate_t;

	bstate_t            state_q;
	logic [PADW-1:0]    w_q;
	logic [BASE_W-1:0]  base_q;
	logic [DIGIT_W-1:0] rem_q;
	logic [CHK_W-1:0]   chunk_q;
	logic [CW-1:0]      cnt_q;
	logic [AW-1:0]      idx_q;
	logic               ov_q, olast_q;
	logic [CHAR_W-1:0]  och_q;
	status_t            ost_q;

	logic [DIGIT_W:0]   div_r;
	logic [DBITS-1:0]   qbits;
	logic [DIGIT_W-1:0] rem_nx;
	logic [PADW-1:0]    w_shift;
	logic               out_free, w_zero, last_chunk, pop_flag;
	logic               load_flag, load_digit, flag_out;
	logic               ram_we;
	logic [DIGIT_W-1:0] ram_wdata, ram_rdata;

	// one chunk of long division by the base: DBITS quotient bits per cycle
	always_comb begin
		div_r = {1'b0, rem_q};
		qbits = '0;
		for (int i = 0; i < DBITS; i++) begin
			div_r = {div_r[DIGIT_W-1:0], w_q[PADW-1-i]};
			qbits[DBITS-1-i] = (div_r >= {1'b0, base_q});
			if (qbits[DBITS-1-i]) begin
				div_r = div_r - {1'b0, base_q};
			end
		end
		rem_nx = div_r[DIGIT_W-1:0];
	end

	assign w_shift    = PADW'({w_q, qbits});
	assign w_zero     = (w_q == '0);
	assign last_chunk = (chunk_q == CHK_W'(CHUNKS - 1));
	assign out_free   = !ov_q || dig.ready;
	assign pop_flag   = q_valid && (q_ctl.status != STATUS_OK);

	// flagged items go straight to the output register, so they wait for it
	assign q_ready = (state_q == B_IDLE) && ((q_ctl.status == STATUS_OK) || out_free);

	// output register loads: a flagged item or a digit read from the store
	assign load_flag  = (state_q == B_IDLE) && q_valid && q_ready && pop_flag;
	assign load_digit = (state_q == B_LD);

	// digit store writes: a remainder per division, or the lone zero digit
	assign ram_we    = ((state_q == B_DIV) && last_chunk) ||
	                   ((state_q == B_CHECK) && w_zero && (cnt_q == '0));
	assign ram_wdata = (state_q == B_DIV) ? rem_nx : '0;

	rcde_ram #(
		.WIDTH (DIGIT_W),
		.DEPTH (MAX_DIGITS)
	) u_digit_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_q[AW-1:0]),
		.wdata (ram_wdata),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			ov_q    <= 1'b0;
			chunk_q <= '0;
			cnt_q   <= '0;
			idx_q   <= '0;
		end else begin
			if (load_flag || load_digit) begin
				ov_q <= 1'b1;
			end else if (ov_q && dig.ready) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (q_valid && q_ready) begin
						if (pop_flag) begin
							och_q   <= '0;
							olast_q <= 1'b1;
							ost_q   <= q_ctl.status;
						end else begin
							w_q     <= PADW'(q_value);
							base_q  <= q_ctl.base;
							cnt_q   <= '0;
							state_q <= B_CHECK;
						end
					end
				end
				B_CHECK: begin
					if (w_zero && (cnt_q == '0)) begin
						cnt_q   <= CW'(1);
						idx_q   <= '0;
						state_q <= B_RD;
					end else if (w_zero || (cnt_q == CW'(MAX_DIGITS))) begin
						idx_q   <= AW'(cnt_q - CW'(1));
						state_q <= B_RD;
					end else begin
						rem_q   <= '0;
						chunk_q <= '0;
						state_q <= B_DIV;
					end
				end
				B_DIV: begin
					rem_q   <= rem_nx;
					w_q     <= w_shift;
					chunk_q <= chunk_q + 1'b1;
					if (last_chunk) begin
						cnt_q   <= cnt_q + CW'(1);
						state_q <= B_CHECK;
					end
				end
				B_RD: begin
					if (out_free) begin
						state_q <= B_LD;
					end
				end
				B_LD: begin
					och_q   <= digit_glyph(ram_rdata);
					olast_q <= (idx_q == '0);
					ost_q   <= STATUS_OK;
					if (idx_q == '0) begin
						state_q <= B_IDLE;
					end else begin
						idx_q   <= idx_q - 1'b1;
						state_q <= B_RD;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	assign dig.valid      = ov_q;
	assign dig.digit_char = och_q;
	assign dig.last       = olast_q;
	assign dig.status     = ost_q;

	assign flag_out = ov_q && (ost_q != STATUS_OK);

	`RCDE_ASSERT(a_back_flag_single, flag_out |-> olast_q && (och_q == '0), "bad flagged item")
	`RCDE_ASSERT(a_back_ram_bound, ram_we |-> (cnt_q < CW'(MAX_DIGITS)), "digit store overrun")
	`RCDE_ASSERT(a_back_load_free, (state_q == B_LD) |-> !ov_q, "output register overwritten")
endmodule

// ===== hdl/radix_calculator_digit_emitter_core.sv =====
// Top level of the radix digit emitter: front end, request queue, back end.
// Depends on rcde_pkg, rcde_in_if, rcde_out_if, rcde_front, rcde_queue, rcde_back.
//
//   channel  dir  payload                               handshake
//   cmd      in   mode, operand_a, operand_b, base      cmd.valid / cmd.ready
//   dig      out  digit_char, last, status              dig.valid / dig.ready
//
// Front: accepts in F_IDLE, then goes straight to F_PUSH (convert, add, subtract,
// flags), or first through F_MUL (multiply, three 32x32 partial products) or F_DIV
// (divide, a quotient bit a cycle). Back: for each digit, division by the base in
// B_CHECK and B_DIV (8 bits a cycle); then, per digit, B_RD and B_LD read the digit
// RAM and load the output. The front overlaps the back end's work.
// Reset clears all control state; stalling dig holds the output register, and
// the two-entry queue lets the front take new requests meanwhile.
module radix_calculator_digit_emitter_core #(
	parameter int VALUE_BITS = rcde_pkg::VALUE_BITS_DEF,
	parameter int MAX_DIGITS = rcde_pkg::MAX_DIGITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	rcde_in_if.sink     cmd,
	rcde_out_if.source  dig
);
	import rcde_pkg::*;

	localparam int QW = CTL_W + VALUE_BITS;

	logic                  push_valid, push_ready, pop_valid, pop_ready;
	qctl_t                 push_ctl, pop_ctl;
	logic [VALUE_BITS-1:0] push_value, pop_value;
	logic [QW-1:0]         push_data, pop_data;

	rcde_front #(
		.VALUE_BITS (VALUE_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_ctl   (push_ctl),
		.push_value (push_value)
	);

	assign push_data = {push_ctl, push_value};

	rcde_queue #(
		.WIDTH (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (push_valid),
		.wr_ready (push_ready),
		.wr_data  (push_data),
		.rd_valid (pop_valid),
		.rd_ready (pop_ready),
		.rd_data  (pop_data)
	);

	assign pop_ctl   = qctl_t'(pop_data[QW-1:VALUE_BITS]);
	assign pop_value = pop_data[VALUE_BITS-1:0];

	rcde_back #(
		.VALUE_BITS (VALUE_BITS),
		.MAX_DIGITS (MAX_DIGITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (pop_valid),
		.q_ready (pop_ready),
		.q_ctl   (pop_ctl),
		.q_value (pop_value),
		.dig     (dig)
	);
endmodule

// ===== tb/rcde_digit_checker.sv =====
// Scoreboard for the radix digit emitter: watches the request and digit channels,
// predicts the digit items of each request and compares them in order.
// Depends on rcde_pkg, rcde_in_if, rcde_out_if.
`timescale 1ns / 100ps

module rcde_digit_checker (
	input  logic clk,
	input  logic arst_n,
	rcde_in_if   cmd,
	rcde_out_if  dig,
	output int   fail_count,
	output int   pending,
	output int   requests_seen,
	output int   digits_seen,
	output int   flags_seen
);
	import rcde_pkg::*;

	localparam int MAX_PRINT = 50;
	localparam int EXP_DEPTH = 1024;	// far above the digit items that can be in flight
	// glyph for digit value d sits at byte 35-d (first character is the MSB)
	localparam logic [8*36-1:0] GLYPHS = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
		status_t           status;
	} digit_item_t;

	// expected digit items, ring written at exp_wr and read at exp_rd
	digit_item_t exp_mem [EXP_DEPTH];
	int          exp_wr;
	int          exp_rd;
	digit_item_t want;

	// predictor state
	logic [OPERAND_W-1:0] work_val;
	logic [DIGIT_W-1:0]   digit_buf [MAX_DIGITS_DEF];
	int                   n_digits;

	int fail_total;
	int req_total;
	int dig_total;
	int flag_total;

	initial begin
		fail_total = 0;
		req_total  = 0;
		dig_total  = 0;
		flag_total = 0;
		work_val   = '0;
		n_digits   = 0;
		exp_wr     = 0;
		exp_rd     = 0;
	end

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned exp_val);
		if (fail_total < MAX_PRINT)
			$display("MISMATCH at digit item %0d: %s got %0h expected %0h",
				dig_total, what, got, exp_val);
		fail_total++;
	endtask

	// append one expected item
	function automatic void add_expected(input digit_item_t e);
		exp_mem[exp_wr % EXP_DEPTH] = e;
		exp_wr++;
	endfunction

	// one flagged item, conversion state cleared
	function automatic void queue_flag(input status_t code);
		digit_item_t e;
		work_val  = '0;
		n_digits  = 0;
		e.ch      = '0;
		e.last    = 1'b1;
		e.status  = code;
		add_expected(e);
		flag_total++;
	endfunction

	// form the value of one request and queue its digits, MSB first
	function automatic void predict_digits(input logic [MODE_W-1:0] m,
			input logic [OPERAND_W-1:0] a, input logic [OPERAND_W-1:0] b,
			input logic [BASE_W-1:0] bs);
		logic [OPERAND_W-1:0] v;
		logic [DIGIT_W-1:0]   d;
		digit_item_t          e;
		if (bs < BASE_MIN || bs > BASE_MAX) begin
			queue_flag(STATUS_BAD_BASE);
			return;
		end
		case (m)
			MODE_ADD: v = a + b;
			MODE_SUB: v = (a > b) ? a - b : '0;
			MODE_MUL: v = a * b;
			MODE_DIV: begin
				if (b == '0) begin
					queue_flag(STATUS_DIV_ZERO);
					return;
				end
				v = a / b;
			end
			default: v = a;	// convert and the spare modes
		endcase
		work_val = v;
		n_digits = 0;
		if (work_val == '0) begin
			digit_buf[0] = '0;
			n_digits     = 1;
		end
		while (work_val != '0 && n_digits < MAX_DIGITS_DEF) begin
			digit_buf[n_digits] = DIGIT_W'(work_val % OPERAND_W'(bs));
			work_val            = work_val / OPERAND_W'(bs);
			n_digits++;
		end
		for (int k = n_digits - 1; k >= 0; k--) begin
			d        = digit_buf[k];
			e.ch     = GLYPHS[8*(35-int'(d)) +: CHAR_W];
			e.last   = (k == 0);
			e.status = STATUS_OK;
			add_expected(e);
		end
	endfunction

	// compare digits first so a stray item never matches this edge's request
	always @(posedge clk) begin
		if (arst_n) begin
			if (dig.valid && dig.ready) begin
				if (exp_wr == exp_rd) begin
					report_mismatch("unexpected item, char", dig.digit_char, 0);
				end else begin
					want = exp_mem[exp_rd % EXP_DEPTH];
					exp_rd++;
					if (dig.digit_char !== want.ch)
						report_mismatch("digit_char", dig.digit_char, want.ch);
					if (dig.last !== want.last)
						report_mismatch("last", dig.last, want.last);
					if (dig.status !== want.status)
						report_mismatch("status", dig.status, want.status);
				end
				dig_total++;
			end
			if (cmd.valid && cmd.ready) begin
				predict_digits(cmd.mode, cmd.operand_a, cmd.operand_b, cmd.base);
				req_total++;
			end
		end
		fail_count    <= fail_total;
		pending       <= exp_wr - exp_rd;
		requests_seen <= req_total;
		digits_seen   <= dig_total;
		flags_seen    <= flag_total;
	end

endmodule

// ===== tb/radix_calculator_digit_emitter_core_tb.sv =====
// Testbench top for the radix digit emitter: clock, reset, request stimulus,
// digit back-pressure, watchdog and verdict. Depends on rcde_pkg, the channel
// interfaces, radix_calculator_digit_emitter_core and rcde_digit_checker.
`timescale 1ns / 100ps

module radix_calculator_digit_emitter_core_tb;
	import rcde_pkg::*;

	localparam int RANDOM_ITEMS = 288;
	localparam int STALL_LIMIT  = 5000;	// cycles with no item moving on either side
	localparam int DRAIN_CYCLES = 1000;	// extra wait after the last expected digit item has been seen

	localparam logic [MODE_W-1:0]    MODE_SPARE = 3'd5;	// first unused mode
	localparam logic [OPERAND_W-1:0] ALL_ONES   = '1;

	logic clk;
	logic arst_n;

	int src_idle_pct;
	int snk_idle_pct;
	int stall_cycles;

	int fail_count;
	int pending;
	int requests_seen;
	int digits_seen;
	int flags_seen;

	rcde_in_if  cmd_if ();
	rcde_out_if dig_if ();

	radix_calculator_digit_emitter_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_if),
		.dig    (dig_if)
	);

	rcde_digit_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd_if),
		.dig           (dig_if),
		.fail_count    (fail_count),
		.pending       (pending),
		.requests_seen (requests_seen),
		.digits_seen   (digits_seen),
		.flags_seen    (flags_seen)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// digit side back-pressure
	initial begin
		dig_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			dig_if.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// watchdog: no item moved for too long
	always @(posedge clk) begin
		if (!arst_n || (cmd_if.valid && cmd_if.ready) || (dig_if.valid && dig_if.ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Watchdog: no progress for %0d cycles, %0d digit items outstanding",
					stall_cycles, pending);
				$display("Verification failed");
				$finish;
			end
		end
	end

	// hand one request over, with random idle cycles ahead of it
	task automatic send_request(input logic [MODE_W-1:0] m, input logic [OPERAND_W-1:0] a,
			input logic [OPERAND_W-1:0] b, input logic [BASE_W-1:0] bs);
		while ($urandom_range(99) < src_idle_pct) begin
			cmd_if.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_if.valid     <= 1'b1;
		cmd_if.mode      <= m;
		cmd_if.operand_a <= a;
		cmd_if.operand_b <= b;
		cmd_if.base      <= bs;
		do @(posedge clk); while (!cmd_if.ready);
	endtask

	// operand shapes: full range, small, zero, all ones, shifted, power of two
	function automatic logic [OPERAND_W-1:0] rand_operand();
		logic [OPERAND_W-1:0] full;
		logic [OPERAND_W-1:0] r;
		full = {$urandom, $urandom};
		case ($urandom_range(5))
			0: r = full;
			1: r = OPERAND_W'($urandom_range(1000));
			2: r = '0;
			3: r = ALL_ONES;
			4: r = full >> $urandom_range(63);
			default: r = OPERAND_W'(1) << $urandom_range(63);
		endcase
		return r;
	endfunction

	function automatic logic [BASE_W-1:0] rand_base();
		logic [BASE_W-1:0] bs;
		if ($urandom_range(99) < 88)
			bs = BASE_W'($urandom_range(BASE_MAX, BASE_MIN));
		else if ($urandom_range(1) == 0)
			bs = BASE_W'($urandom_range(1));
		else
			bs = BASE_W'($urandom_range(63, 37));
		return bs;
	endfunction

	initial begin
		logic [MODE_W-1:0]    m;
		logic [OPERAND_W-1:0] a;
		logic [OPERAND_W-1:0] b;
		arst_n           <= 1'b0;
		cmd_if.valid     <= 1'b0;
		cmd_if.mode      <= MODE_CONVERT;
		cmd_if.operand_a <= '0;
		cmd_if.operand_b <= '0;
		cmd_if.base      <= BASE_MIN;
		src_idle_pct     = 18;
		snk_idle_pct     = 58;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: zero, widest values, wrap, saturation, flags, spare modes
		send_request(MODE_CONVERT, '0, '0, 6'd10);
		send_request(MODE_CONVERT, ALL_ONES, '0, BASE_MIN);
		send_request(MODE_CONVERT, ALL_ONES, ALL_ONES, BASE_MAX);
		send_request(MODE_CONVERT, 64'h8000_0000_0000_0000, '0, 6'd16);
		send_request(MODE_CONVERT, 64'd35, '0, BASE_MAX);
		send_request(MODE_CONVERT, 64'd1, '0, BASE_MIN);
		send_request(MODE_ADD, ALL_ONES, 64'd1, 6'd10);
		send_request(MODE_ADD, ALL_ONES, ALL_ONES, 6'd16);
		send_request(MODE_SUB, 64'd5, 64'd9, 6'd10);
		send_request(MODE_SUB, ALL_ONES, 64'd1, 6'd8);
		send_request(MODE_SUB, 64'd1234, 64'd1234, 6'd3);
		send_request(MODE_MUL, ALL_ONES, ALL_ONES, BASE_MAX);
		send_request(MODE_MUL, 64'h1_0000_0000, 64'h1_0000_0000, 6'd10);
		send_request(MODE_MUL, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 6'd7);
		send_request(MODE_DIV, ALL_ONES, 64'd1, 6'd3);
		send_request(MODE_DIV, 64'd100, '0, 6'd10);
		send_request(MODE_DIV, 64'd7, 64'd9, 6'd10);
		send_request(MODE_CONVERT, 64'd42, '0, 6'd0);
		send_request(MODE_ADD, 64'd42, 64'd1, 6'd1);
		send_request(MODE_SUB, 64'd42, 64'd1, 6'd37);
		// bad base wins over division by zero
		send_request(MODE_DIV, 64'd42, '0, 6'd63);
		send_request(MODE_SPARE, 64'hDEAD_BEEF_CAFE_F00D, ALL_ONES, 6'd35);
		send_request(MODE_SPARE + 3'd1, ALL_ONES, 64'd3, BASE_MAX);
		send_request(MODE_SPARE + 3'd2, 64'hA5A5_A5A5_5A5A_5A5A, 64'd7, BASE_MIN);

		// random requests, three idle profiles
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS / 3) begin
				src_idle_pct = 58;
				snk_idle_pct = 18;
			end else if (i == 2 * RANDOM_ITEMS / 3) begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end
			if ($urandom_range(99) < 90)
				m = MODE_W'($urandom_range(MODE_DIV));
			else
				m = MODE_W'($urandom_range(7, MODE_SPARE));
			a = rand_operand();
			b = rand_operand();
			if (m == MODE_DIV && $urandom_range(99) < 12)
				b = '0;
			send_request(m, a, b, rand_base());
		end
		cmd_if.valid <= 1'b0;

		// drain: let the checker see the last request, then wait for its digits
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Summary: %0d requests, %0d digit items checked, %0d flagged results",
			requests_seen, digits_seen, flags_seen);
		$display("Summary: all modes, bases 0..63, idle profiles 18/58, 58/18 and none");
		if (fail_count == 0 && pending == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
